// File: hw/rtl/first_fit_region_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define FFRA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFRA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFRA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFRA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and codes for the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;
    localparam int unsigned FieldBits = 32;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ID    = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_NOT_ALLOC = 3'd3,
        ST_LIST_FULL = 3'd4
    } status_t;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        func_t                 func;
        logic [4:0]            region_id;
        logic [FieldBits-1:0]  size;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [FieldBits-1:0]  addr;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RREG,      // region entry read in flight
        S_DECIDE,    // region entry available
        S_SRCH,      // hole entry read in flight
        S_SCHK,      // hole entry available, check fit
        S_DRD,       // drop: read next hole
        S_DWR,       // drop: write it one lower
        S_PRD,       // push: read hole below
        S_PWR,       // push: write it one higher
        S_PHEAD,     // push: write head
        S_DONE
    } fsm_t;
endpackage

// File: hw/rtl/ffra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ffra_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: hw/rtl/first_fit_region_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// Region table plus newest-first hole list, first-fit search, break pointer.
// ----------------------------------------------------------------------------
// channel | direction | valid     | stall     | payload
// req     | in        | req_valid | req_stall | req   (ffra_pkg::req_t)
// rsp     | out       | rsp_valid | rsp_stall | rsp   (ffra_pkg::rsp_t)
// cfg     | in        | cfg_we    | -         | cfg_index, cfg_data
//
// One word at a time. Cost is dominated by the single-port hole RAM:
// table read and decide after acceptance, a read and a check per hole probed,
// a read and a write per hole shifted on a drop or a push (plus the head write
// on a push), then the result is presented and the block returns to idle.
// Region table is valid-bit backed, so reset clears it at once; no sweep.
// A result held by rsp_stall blocks the next word until taken.
`include "first_fit_region_allocator_defines.svh"
module first_fit_region_allocator #(
    parameter int unsigned REGION_SLOTS = 32,
    parameter int unsigned HOLE_SLOTS   = 16,
    parameter int unsigned ADDR_BITS    = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  ffra_pkg::req_t             req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output ffra_pkg::rsp_t             rsp,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [31:0]                cfg_data
);
    localparam int unsigned RB = $clog2(REGION_SLOTS);
    localparam int unsigned HB = $clog2(HOLE_SLOTS);
    localparam int unsigned CB = $clog2(HOLE_SLOTS + 1);
    localparam int unsigned FB = ffra_pkg::FieldBits;

    // ---------------- state ----------------
    ffra_pkg::fsm_t          state_reg, state_next;
    ffra_pkg::req_t          req_reg, req_next;
    logic [ADDR_BITS-1:0]    base_reg, base_next;
    logic [ADDR_BITS-1:0]    limit_reg, limit_next;
    logic [ADDR_BITS-1:0]    brk_reg, brk_next;
    logic [CB-1:0]           cnt_reg, cnt_next;
    logic [CB-1:0]           idx_reg, idx_next;
    logic [REGION_SLOTS-1:0] rvalid_reg, rvalid_next;
    ffra_pkg::rsp_t          rsp_reg, rsp_next;
    logic [2*ADDR_BITS-1:0]  tmp_reg, tmp_next;   // freed hole waiting for the head write

    // ---------------- memories ----------------
    logic                   r_we;
    logic [RB-1:0]          r_addr;
    logic [2*ADDR_BITS-1:0] r_wdata, r_rdata;
    logic                   h_we;
    logic [HB-1:0]          h_addr;
    logic [2*ADDR_BITS-1:0] h_wdata, h_rdata;

    ffra_ram #(.WIDTH(2*ADDR_BITS), .DEPTH(REGION_SLOTS)) u_region (
        .clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata));
    ffra_ram #(.WIDTH(2*ADDR_BITS), .DEPTH(HOLE_SLOTS)) u_hole (
        .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));

    // region entry seen through its valid bit (unwritten reads as unused)
    logic [ADDR_BITS-1:0] rs, re, hs, he, sz;
    logic [RB-1:0]        rid;
    logic [ADDR_BITS:0]   bp_sum;
    assign rid = req_reg.region_id[RB-1:0];
    assign rs = rvalid_reg[rid] ? r_rdata[2*ADDR_BITS-1:ADDR_BITS] : '0;
    assign re = rvalid_reg[rid] ? r_rdata[ADDR_BITS-1:0] : '0;
    assign hs = h_rdata[2*ADDR_BITS-1:ADDR_BITS];
    assign he = h_rdata[ADDR_BITS-1:0];
    assign sz = ADDR_BITS'(req_reg.size);
    assign bp_sum = {1'b0, brk_reg} + {1'b0, sz};

    logic                 id_bad;
    logic [ADDR_BITS-1:0] span;
    logic                 size_hi;
    generate
        if (ADDR_BITS < FB)
        begin : g_narrow
            assign size_hi = |req_reg.size[FB-1:(ADDR_BITS < FB ? ADDR_BITS : 0)];
        end
        else
        begin : g_wide
            assign size_hi = 1'b0;
        end
    endgenerate
    assign id_bad = (32'(req_reg.region_id) >= REGION_SLOTS);
    assign span   = he - hs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ffra_pkg::S_IDLE;
            base_reg   <= '0;
            limit_reg  <= '1;
            brk_reg    <= '0;
            cnt_reg    <= '0;
            rvalid_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            limit_reg  <= limit_next;
            brk_reg    <= brk_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        idx_reg <= idx_next;
        rsp_reg <= rsp_next;
        tmp_reg <= tmp_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        base_next   = base_reg;
        limit_next  = limit_reg;
        brk_next    = brk_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        rvalid_next = rvalid_reg;
        rsp_next    = rsp_reg;
        tmp_next    = tmp_reg;
        r_we    = 1'b0;
        r_addr  = rid;
        r_wdata = '0;
        h_we    = 1'b0;
        h_addr  = idx_reg[HB-1:0];
        h_wdata = tmp_reg;
        req_stall = (state_reg != ffra_pkg::S_IDLE);
        rsp_valid = (state_reg == ffra_pkg::S_DONE);
        rsp       = rsp_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                ffra_pkg::CFG_HEAP_BASE:
                begin
                    base_next = ADDR_BITS'(cfg_data);
                    brk_next  = ADDR_BITS'(cfg_data);
                end
                ffra_pkg::CFG_HEAP_LIMIT: limit_next = ADDR_BITS'(cfg_data);
                default: ;
            endcase
        end

        case (state_reg)
            ffra_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    r_addr     = req.region_id[RB-1:0];
                    state_next = ffra_pkg::S_RREG;
                end
            end
            ffra_pkg::S_RREG: state_next = ffra_pkg::S_DECIDE;
            ffra_pkg::S_DECIDE:
            begin
                rsp_next.addr = '0;
                if (id_bad)
                begin
                    rsp_next.status = ffra_pkg::ST_BAD_ID;
                    state_next      = ffra_pkg::S_DONE;
                end
                else if (req_reg.func == ffra_pkg::FUNC_ALLOC)
                begin
                    idx_next = '0;
                    if (cnt_reg != '0)
                    begin
                        h_addr     = '0;
                        state_next = ffra_pkg::S_SRCH;
                    end
                    else
                    begin
                        state_next = ffra_pkg::S_SCHK;
                    end
                end
                else if (rs == '0 && re == '0)
                begin
                    rsp_next.status = ffra_pkg::ST_NOT_ALLOC;
                    state_next      = ffra_pkg::S_DONE;
                end
                else if (rs >= re)
                begin
                    r_we = 1'b1;
                    rvalid_next[rid] = 1'b0;
                    rsp_next.status  = ffra_pkg::ST_NOT_ALLOC;
                    state_next       = ffra_pkg::S_DONE;
                end
                else if (32'(cnt_reg) >= HOLE_SLOTS)
                begin
                    rsp_next.status = ffra_pkg::ST_LIST_FULL;
                    state_next      = ffra_pkg::S_DONE;
                end
                else
                begin
                    r_we = 1'b1;
                    rvalid_next[rid] = 1'b0;
                    tmp_next = {rs, re};   // hole to push
                    rsp_next.status = ffra_pkg::ST_OK;
                    idx_next = cnt_reg;
                    if (cnt_reg == '0)
                    begin
                        state_next = ffra_pkg::S_PHEAD;
                    end
                    else
                    begin
                        h_addr     = HB'(cnt_reg - 1'b1);
                        state_next = ffra_pkg::S_PRD;
                    end
                end
            end
            ffra_pkg::S_SRCH: state_next = ffra_pkg::S_SCHK;
            ffra_pkg::S_SCHK:
            begin
                if (idx_reg < cnt_reg && he >= hs && !size_hi && sz <= span)
                begin
                    r_we    = 1'b1;
                    r_wdata = {hs, hs + sz};
                    rvalid_next[rid] = 1'b1;
                    rsp_next.status  = ffra_pkg::ST_OK;
                    rsp_next.addr    = FB'(hs);
                    if (sz < span)
                    begin
                        h_we       = 1'b1;
                        h_wdata    = {hs + sz, he};
                        state_next = ffra_pkg::S_DONE;
                    end
                    else if (idx_reg + 1'b1 < cnt_reg)
                    begin
                        h_addr     = HB'(idx_reg + 1'b1);
                        state_next = ffra_pkg::S_DRD;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = ffra_pkg::S_DONE;
                    end
                end
                else if (idx_reg + 1'b1 < cnt_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    h_addr     = HB'(idx_reg + 1'b1);
                    state_next = ffra_pkg::S_SRCH;
                end
                else if (brk_reg > limit_reg || size_hi || sz > limit_reg - brk_reg)
                begin
                    rsp_next.status = ffra_pkg::ST_NO_SPACE;
                    rsp_next.addr   = '0;
                    state_next      = ffra_pkg::S_DONE;
                end
                else
                begin
                    r_we    = 1'b1;
                    r_wdata = {brk_reg, bp_sum[ADDR_BITS-1:0]};
                    rvalid_next[rid] = 1'b1;
                    rsp_next.status  = ffra_pkg::ST_OK;
                    rsp_next.addr    = FB'(brk_reg);
                    brk_next         = bp_sum[ADDR_BITS-1:0];
                    state_next       = ffra_pkg::S_DONE;
                end
            end
            ffra_pkg::S_DRD:
            begin
                // hold the read on the entry above; it lands in S_DWR
                h_addr     = HB'(idx_reg + 1'b1);
                state_next = ffra_pkg::S_DWR;
            end
            ffra_pkg::S_DWR:
            begin
                h_we    = 1'b1;
                h_wdata = h_rdata;
                if (idx_reg + 2'd2 < cnt_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ffra_pkg::S_DRD;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = ffra_pkg::S_DONE;
                end
            end
            ffra_pkg::S_PRD:
            begin
                h_addr     = HB'(idx_reg - 1'b1);
                state_next = ffra_pkg::S_PWR;
            end
            ffra_pkg::S_PWR:
            begin
                h_we    = 1'b1;
                h_wdata = h_rdata;
                idx_next = idx_reg - 1'b1;
                if (idx_reg == CB'(1))
                begin
                    state_next = ffra_pkg::S_PHEAD;
                end
                else
                begin
                    state_next = ffra_pkg::S_PRD;
                end
            end
            ffra_pkg::S_PHEAD:
            begin
                h_we       = 1'b1;
                h_addr     = '0;
                h_wdata    = tmp_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ffra_pkg::S_DONE;
            end
            ffra_pkg::S_DONE:
            begin
                if (!rsp_stall)
                begin
                    state_next = ffra_pkg::S_IDLE;
                end
            end
            default: state_next = ffra_pkg::S_IDLE;
        endcase
    end

    `FFRA_ASSERT(a_cnt_bound, clk, rst_n, (32'(cnt_reg) <= HOLE_SLOTS), "hole count over capacity")
    `FFRA_ASSERT(a_rsp_hold, clk, rst_n, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)), "result changed under stall")
    `FFRA_ASSERT(a_one_word, clk, rst_n, rsp_valid |-> req_stall, "request taken while result pending")
    `FFRA_ASSERT(a_ok_status, clk, rst_n, (rsp_valid && rsp.status != ffra_pkg::ST_OK) |-> (rsp.addr == '0), "failed result with address")
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for first_fit_region_allocator: a queue-fed request
// driver, a response monitor checked against an in-bench allocator model,
// several heap_base / heap_limit settings, random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    localparam int unsigned NREG     = 32;
    localparam int unsigned NHOLE    = 16;
    localparam int unsigned DRAIN    = 100;    // cycles after the last word
    localparam int unsigned WDOG_MAX = 20000;  // cycles with no word moved

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    ffra_pkg::req_t req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    ffra_pkg::rsp_t rsp;
    logic           cfg_we = 1'b0;
    logic           cfg_index = 1'b0;
    logic [31:0]    cfg_data = '0;

    ffra_pkg::req_t req_q[$];    // words waiting to be driven
    ffra_pkg::rsp_t want_q[$];   // responses owed by the allocator
    int unsigned    err_cnt = 0;
    bit             quiet = 1'b0; // no idling while set
    int unsigned    wdog = 0;

    // allocator model state
    logic [31:0] m_base, m_limit, m_brk;
    logic [31:0] m_rs[NREG];
    logic [31:0] m_re[NREG];
    logic [31:0] m_hs[NHOLE];
    logic [31:0] m_he[NHOLE];
    int unsigned m_holes;

    always #5 clk = ~clk;

    first_fit_region_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model of one request: updates the tables and returns the response.
    function automatic ffra_pkg::rsp_t serve_word(ffra_pkg::req_t w);
        ffra_pkg::rsp_t r;
        int unsigned    id;
        int unsigned    k;
        bit             hit;
        logic [31:0]    s, e;
        r.status = ffra_pkg::ST_OK;
        r.addr   = '0;
        id  = w.region_id;
        hit = 1'b0;
        if (w.func == ffra_pkg::FUNC_ALLOC)
        begin
            // first fit, newest hole first
            for (k = 0; k < m_holes && !hit; k++)
            begin
                s = m_hs[k];
                e = m_he[k];
                if (e >= s && w.size <= e - s)
                begin
                    hit     = 1'b1;
                    m_rs[id] = s;
                    m_re[id] = s + w.size;
                    r.addr  = s;
                    if (w.size < e - s)
                    begin
                        m_hs[k] = s + w.size;
                    end
                    else
                    begin
                        // hole used up: close the gap
                        for (int j = k; j + 1 < m_holes; j++)
                        begin
                            m_hs[j] = m_hs[j+1];
                            m_he[j] = m_he[j+1];
                        end
                        m_holes--;
                    end
                end
            end
            if (!hit)
            begin
                // nothing fits: grow at the break unless past the limit
                if (m_brk > m_limit || w.size > m_limit - m_brk)
                begin
                    r.status = ffra_pkg::ST_NO_SPACE;
                end
                else
                begin
                    m_rs[id] = m_brk;
                    m_re[id] = m_brk + w.size;
                    r.addr  = m_brk;
                    m_brk   = m_brk + w.size;
                end
            end
        end
        else
        begin
            s = m_rs[id];
            e = m_re[id];
            if (s == 0 && e == 0)
            begin
                r.status = ffra_pkg::ST_NOT_ALLOC;
            end
            else if (s >= e)
            begin
                // empty range: entry cleared, no hole added
                m_rs[id] = '0;
                m_re[id] = '0;
                r.status = ffra_pkg::ST_NOT_ALLOC;
            end
            else if (m_holes >= NHOLE)
            begin
                r.status = ffra_pkg::ST_LIST_FULL;
            end
            else
            begin
                for (int j = m_holes; j > 0; j--)
                begin
                    m_hs[j] = m_hs[j-1];
                    m_he[j] = m_he[j-1];
                end
                m_hs[0] = s;
                m_he[0] = e;
                m_holes++;
                m_rs[id] = '0;
                m_re[id] = '0;
            end
        end
        return r;
    endfunction

    function automatic ffra_pkg::req_t mk_word(ffra_pkg::func_t f, int unsigned id,
                                               logic [31:0] sz);
        ffra_pkg::req_t w;
        w.func      = f;
        w.region_id = id[4:0];
        w.size      = sz;
        return w;
    endfunction

    // Mostly modest sizes so the heap lasts; a few wide ones to hit every bit.
    function automatic logic [31:0] rand_size();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 8)  return 32'd0;
        if (p < 55) return $urandom_range(1, 64);
        if (p < 85) return $urandom_range(1, 4096);
        if (p < 92 && m_holes > 0) return m_he[0] - m_hs[0];  // likely exact fit
        return $urandom;
    endfunction

    function automatic ffra_pkg::req_t rand_word();
        if ($urandom_range(99) < 55)
            return mk_word(ffra_pkg::FUNC_ALLOC, $urandom_range(NREG - 1), rand_size());
        return mk_word(ffra_pkg::FUNC_FREE, $urandom_range(NREG - 1), $urandom);
    endfunction

    // Driver: predict on acceptance, then present the next word or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                want_q.push_back(serve_word(req));
            end
            if (!req_valid || !req_stall)
            begin
                if (req_q.size() > 0 && (quiet || $urandom_range(99) >= 14))
                begin
                    req       <= req_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted response with the oldest owed one.
    always @(posedge clk or negedge rst_n)
    begin
        ffra_pkg::rsp_t w;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (want_q.size() == 0)
                begin
                    $error("unexpected response status=%0d addr=%h", rsp.status, rsp.addr);
                    err_cnt++;
                end
                else
                begin
                    w = want_q.pop_front();
                    if (rsp.status !== w.status)
                    begin
                        $error("status: expected %0d, got %0d", w.status, rsp.status);
                        err_cnt++;
                    end
                    if (rsp.addr !== w.addr)
                    begin
                        $error("addr: expected %h, got %h", w.addr, rsp.addr);
                        err_cnt++;
                    end
                end
            end
            rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 14);
        end
    end

    // Watchdog on cycles where neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic cfg_write(ffra_pkg::cfg_idx_t idx, logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        if (idx == ffra_pkg::CFG_HEAP_BASE)
        begin
            m_base = v;
            m_brk  = v;
        end
        else
        begin
            m_limit = v;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender holds off until every owed response is back.
    task automatic drain();
        wait (req_q.size() == 0 && !req_valid && want_q.size() == 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic rand_phase(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            req_q.push_back(rand_word());
        drain();
    endtask

    initial
    begin
        logic [31:0] b;
        m_base  = '0;
        m_limit = '1;
        m_brk   = '0;
        m_holes = 0;
        for (int i = 0; i < NREG; i++)
        begin
            m_rs[i] = '0;
            m_re[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config, break at zero.
        req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, 0, 32'd0));   // empty range at 0
        req_q.push_back(mk_word(ffra_pkg::FUNC_FREE, 0, '1));       // looks unused
        req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, 1, 32'd16));
        req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, 2, 32'd32));
        req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, 31, 32'd48));
        req_q.push_back(mk_word(ffra_pkg::FUNC_FREE, 1, '0));       // hole [0,16)
        req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, 3, 32'd16));  // exact fit, dropped
        req_q.push_back(mk_word(ffra_pkg::FUNC_FREE, 2, '0));       // hole [16,48)
        req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, 4, 32'd8));   // split
        req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, 5, 32'd0));   // zero size in hole
        req_q.push_back(mk_word(ffra_pkg::FUNC_FREE, 5, '0));       // empty range
        req_q.push_back(mk_word(ffra_pkg::FUNC_FREE, 5, '0));       // now unused
        req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, 6, 32'hFFFF_FFFF)); // past limit
        req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, 4, 32'd100)); // overwrite used id
        req_q.push_back(mk_word(ffra_pkg::FUNC_FREE, 9, '0));       // never allocated
        req_q.push_back(mk_word(ffra_pkg::FUNC_FREE, 31, '0));
        req_q.push_back(mk_word(ffra_pkg::FUNC_FREE, 4, '0));
        req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, 7, 32'd24));  // first fit of newest
        drain();

        // Fill the hole list past its capacity.
        cfg_write(ffra_pkg::CFG_HEAP_BASE, 32'h0000_1000);
        cfg_write(ffra_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        for (int i = 8; i < 28; i++)
            req_q.push_back(mk_word(ffra_pkg::FUNC_ALLOC, i, $urandom_range(1, 32)));
        for (int i = 8; i < 28; i++)
            req_q.push_back(mk_word(ffra_pkg::FUNC_FREE, i, '0));   // last ones: list full
        drain();

        // Random phases over a spread of settings; one with no idling.
        quiet = 1'b1;
        rand_phase(300);
        quiet = 1'b0;
        b = $urandom_range(0, 32'h00FF_FFFF);
        cfg_write(ffra_pkg::CFG_HEAP_BASE, b);
        cfg_write(ffra_pkg::CFG_HEAP_LIMIT, b + $urandom_range(0, 60000));
        rand_phase(300);
        cfg_write(ffra_pkg::CFG_HEAP_BASE, 32'hFFFF_FF00);          // near the top
        cfg_write(ffra_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        rand_phase(200);
        cfg_write(ffra_pkg::CFG_HEAP_BASE, 32'h0);                   // no room at all
        cfg_write(ffra_pkg::CFG_HEAP_LIMIT, 32'h0);
        rand_phase(150);
        cfg_write(ffra_pkg::CFG_HEAP_BASE, 32'h0001_0000);           // base above limit
        cfg_write(ffra_pkg::CFG_HEAP_LIMIT, 32'h0000_0100);
        rand_phase(150);
        cfg_write(ffra_pkg::CFG_HEAP_BASE, $urandom);
        cfg_write(ffra_pkg::CFG_HEAP_LIMIT, $urandom);
        rand_phase(150);
        cfg_write(ffra_pkg::CFG_HEAP_BASE, 32'h0000_0040);
        cfg_write(ffra_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        rand_phase(250);

        if (err_cnt == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
